@@ design/sphere_point_to_cube_face_defines.svh @@
`ifndef SPHERE_POINT_TO_CUBE_FACE_DEFINES_SVH
`define SPHERE_POINT_TO_CUBE_FACE_DEFINES_SVH

// same-cycle implication
`define SPCF_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define SPCF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ design/spcf_pkg.sv @@
package spcf_pkg;

  localparam int FRAC_BITS = 30;
  localparam int IO_W      = 32;
  localparam int MAG_W     = FRAC_BITS + 1;
  localparam int SQ_W      = 2 * MAG_W;
  localparam int T_W       = MAG_W + 2;
  localparam int E_W       = 37;
  localparam int P_W       = 36;
  localparam int RAD_W     = 64;
  localparam int ROOT_W    = RAD_W / 2;

  localparam logic signed [IO_W:0] ONE_S    = (IO_W + 1)'(1) <<< FRAC_BITS;
  localparam logic [SQ_W-1:0]      SQ_ROUND = SQ_W'(1) << (FRAC_BITS - 1);
  localparam logic [E_W-1:0]       E_BASE   = E_W'(9) << FRAC_BITS;
  localparam logic [P_W-1:0]       P_BASE   = P_W'(3) << FRAC_BITS;
  localparam logic [ROOT_W-1:0]    LIM      = ROOT_W'(1) << FRAC_BITS;

  typedef enum logic [2:0] {
    FACE_PX = 3'd0,
    FACE_NX = 3'd1,
    FACE_PY = 3'd2,
    FACE_NY = 3'd3,
    FACE_PZ = 3'd4,
    FACE_NZ = 3'd5
  } face_e;

  typedef struct packed {
    logic neg;
    logic zero;
  } sgn_t;

  typedef struct packed {
    face_e face;
    sgn_t  sa;
  } utag_t;

  typedef struct packed {
    utag_t              ut;
    sgn_t               sb;
    logic signed [T_W-1:0] t;
  } side_t;

endpackage

@@ design/sphere_point_to_cube_face.sv @@
// Maps a point on the unit sphere (Q1.30 components) to a cube face and the two
// Q1.30 face coordinates of the inverse cube-to-sphere map. Fully pipelined: one
// transaction per cycle in and out, through 5 front stages (face select,
// squares and the radicand), a 17-stage square root pipeline feeding two more
// in parallel (an input register, then two root bits retired per stage), and
// one output register. A stall at the output holds the whole pipeline;
// in_stall_o rises only while a finished result waits at the output.
module sphere_point_to_cube_face (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic signed [spcf_pkg::IO_W-1:0]  pos_x_i,
  input  logic signed [spcf_pkg::IO_W-1:0]  pos_y_i,
  input  logic signed [spcf_pkg::IO_W-1:0]  pos_z_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [2:0]                        face_o,
  output logic signed [spcf_pkg::IO_W-1:0]  face_u_o,
  output logic signed [spcf_pkg::IO_W-1:0]  face_v_o
);

  localparam int RAD_W  = spcf_pkg::RAD_W;
  localparam int ROOT_W = spcf_pkg::ROOT_W;
  localparam int P_W    = spcf_pkg::P_W;
  localparam int IO_W   = spcf_pkg::IO_W;

  logic en;
  logic out_valid_q;

  logic              f_valid;
  logic [RAD_W-1:0]  f_rad;
  spcf_pkg::side_t   f_side;

  logic              u_valid;
  logic [ROOT_W-1:0] u_root;
  spcf_pkg::side_t   u_side;

  logic [P_W-1:0]    pu, pv;
  logic [RAD_W-1:0]  rad_u, rad_v;

  logic              a_valid, b_valid;
  logic [ROOT_W-1:0] a_root, b_root;
  spcf_pkg::utag_t   a_tag;
  spcf_pkg::sgn_t    b_sgn;

  logic [2:0]             face_q;
  logic signed [IO_W-1:0] face_u_q, face_v_q;

  function automatic logic signed [IO_W-1:0] fin(input logic [ROOT_W-1:0] r,
                                                 input spcf_pkg::sgn_t s);
    logic [ROOT_W-1:0] m;
    m = (r > spcf_pkg::LIM) ? spcf_pkg::LIM : r;
    if (s.zero) begin
      return '0;
    end else if (s.neg) begin
      return -$signed(IO_W'(m));
    end
    return $signed(IO_W'(m));
  endfunction

  assign en         = !(out_valid_q && out_stall_i);
  assign in_stall_o = !en;

  spcf_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (in_valid_i),
    .pos_x_i (pos_x_i),
    .pos_y_i (pos_y_i),
    .pos_z_i (pos_z_i),
    .valid_o (f_valid),
    .rad_o   (f_rad),
    .side_o  (f_side)
  );

  spcf_sqrt #(.RAD_W(RAD_W), .SIDE_W($bits(spcf_pkg::side_t))) u_sqrt_e (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (f_valid),
    .rad_i   (f_rad),
    .side_i  (f_side),
    .valid_o (u_valid),
    .root_o  (u_root),
    .side_o  (u_side)
  );

  always_comb begin
    pu    = spcf_pkg::P_BASE + P_W'(u_side.t) - P_W'(u_root);
    pv    = spcf_pkg::P_BASE - P_W'(u_side.t) - P_W'(u_root);
    rad_u = pu[P_W-1] ? '0 : (RAD_W'(pu[P_W-2:0]) << (spcf_pkg::FRAC_BITS - 1));
    rad_v = pv[P_W-1] ? '0 : (RAD_W'(pv[P_W-2:0]) << (spcf_pkg::FRAC_BITS - 1));
  end

  spcf_sqrt #(.RAD_W(RAD_W), .SIDE_W($bits(spcf_pkg::utag_t))) u_sqrt_u (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (u_valid),
    .rad_i   (rad_u),
    .side_i  (u_side.ut),
    .valid_o (a_valid),
    .root_o  (a_root),
    .side_o  (a_tag)
  );

  spcf_sqrt #(.RAD_W(RAD_W), .SIDE_W($bits(spcf_pkg::sgn_t))) u_sqrt_v (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (u_valid),
    .rad_i   (rad_v),
    .side_i  (u_side.sb),
    .valid_o (b_valid),
    .root_o  (b_root),
    .side_o  (b_sgn)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= a_valid && b_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      face_q   <= a_tag.face;
      face_u_q <= fin(a_root, a_tag.sa);
      face_v_q <= fin(b_root, b_sgn);
    end
  end

  assign out_valid_o = out_valid_q;
  assign face_o      = face_q;
  assign face_u_o    = face_u_q;
  assign face_v_o    = face_v_q;

endmodule

@@ design/spcf_front.sv @@
module spcf_front (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              en_i,
  input  logic                              valid_i,
  input  logic signed [spcf_pkg::IO_W-1:0]  pos_x_i,
  input  logic signed [spcf_pkg::IO_W-1:0]  pos_y_i,
  input  logic signed [spcf_pkg::IO_W-1:0]  pos_z_i,
  output logic                              valid_o,
  output logic [spcf_pkg::RAD_W-1:0]        rad_o,
  output spcf_pkg::side_t                   side_o
);

  localparam int IO_W  = spcf_pkg::IO_W;
  localparam int MAG_W = spcf_pkg::MAG_W;
  localparam int SQ_W  = spcf_pkg::SQ_W;
  localparam int E_W   = spcf_pkg::E_W;
  localparam int FB    = spcf_pkg::FRAC_BITS;

  logic [4:0] v_q;

  logic signed [IO_W-1:0] x1_q, y1_q, z1_q;

  logic signed [IO_W:0] xs, ys, zs, ax, ay, az, a_r, b_r, a_c, b_c, a_m, b_m;
  spcf_pkg::face_e face_d;

  spcf_pkg::face_e face2_q;
  logic [MAG_W-1:0] ma2_q, mb2_q;
  spcf_pkg::sgn_t sa2_q, sb2_q;

  spcf_pkg::utag_t ut3_q, ut4_q, ut5_q;
  spcf_pkg::sgn_t sb3_q, sb4_q, sb5_q;
  logic [SQ_W-1:0] pa3_q, pb3_q;

  logic [SQ_W-1:0] sa_sum, sb_sum;
  logic [MAG_W-1:0] sx_d, sy_d, md_d;
  logic signed [IO_W-1:0] d_d;
  logic [MAG_W-1:0] sx4_q, sy4_q, md4_q, sx5_q, sy5_q;
  logic signed [spcf_pkg::T_W-1:0] t4_q, t5_q;
  logic [SQ_W-1:0] pq5_q;

  logic [SQ_W-1:0] q_sum;
  logic [MAG_W-1:0] q_r;
  logic [E_W-1:0] e_u;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[3:0], valid_i};
    end
  end

  always_comb begin
    xs = (IO_W + 1)'(x1_q);
    ys = (IO_W + 1)'(y1_q);
    zs = (IO_W + 1)'(z1_q);
    ax = (xs < 0) ? -xs : xs;
    ay = (ys < 0) ? -ys : ys;
    az = (zs < 0) ? -zs : zs;
    if (ax > ay && ax > az) begin
      face_d = (xs > 0) ? spcf_pkg::FACE_PX : spcf_pkg::FACE_NX;
      a_r    = (xs > 0) ? ys : -ys;
      b_r    = zs;
    end else if (ay > ax && ay > az) begin
      face_d = (ys > 0) ? spcf_pkg::FACE_PY : spcf_pkg::FACE_NY;
      a_r    = (ys > 0) ? zs : -zs;
      b_r    = xs;
    end else begin
      face_d = (zs > 0) ? spcf_pkg::FACE_PZ : spcf_pkg::FACE_NZ;
      a_r    = (zs > 0) ? xs : -xs;
      b_r    = ys;
    end
    a_c = (a_r > spcf_pkg::ONE_S) ? spcf_pkg::ONE_S :
          (a_r < -spcf_pkg::ONE_S) ? -spcf_pkg::ONE_S : a_r;
    b_c = (b_r > spcf_pkg::ONE_S) ? spcf_pkg::ONE_S :
          (b_r < -spcf_pkg::ONE_S) ? -spcf_pkg::ONE_S : b_r;
    a_m = (a_c < 0) ? -a_c : a_c;
    b_m = (b_c < 0) ? -b_c : b_c;
  end

  always_comb begin
    sa_sum = pa3_q + spcf_pkg::SQ_ROUND;
    sb_sum = pb3_q + spcf_pkg::SQ_ROUND;
    sx_d   = sa_sum[FB+MAG_W-1:FB];
    sy_d   = sb_sum[FB+MAG_W-1:FB];
    d_d    = $signed(IO_W'(sx_d)) - $signed(IO_W'(sy_d));
    md_d   = (d_d < 0) ? MAG_W'(-d_d) : MAG_W'(d_d);
  end

  always_comb begin
    q_sum = pq5_q + spcf_pkg::SQ_ROUND;
    q_r   = q_sum[FB+MAG_W-1:FB];
    e_u   = spcf_pkg::E_BASE + (E_W'(q_r) << 2)
            - E_W'(12) * (E_W'(sx5_q) + E_W'(sy5_q));
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x1_q    <= pos_x_i;
      y1_q    <= pos_y_i;
      z1_q    <= pos_z_i;
      face2_q <= face_d;
      ma2_q   <= a_m[MAG_W-1:0];
      mb2_q   <= b_m[MAG_W-1:0];
      sa2_q   <= '{neg: a_c < 0, zero: a_c == 0};
      sb2_q   <= '{neg: b_c < 0, zero: b_c == 0};
      pa3_q   <= SQ_W'(ma2_q) * SQ_W'(ma2_q);
      pb3_q   <= SQ_W'(mb2_q) * SQ_W'(mb2_q);
      ut3_q   <= '{face: face2_q, sa: sa2_q};
      sb3_q   <= sb2_q;
      sx4_q   <= sx_d;
      sy4_q   <= sy_d;
      md4_q   <= md_d;
      t4_q    <= {d_d, 1'b0};
      ut4_q   <= ut3_q;
      sb4_q   <= sb3_q;
      pq5_q   <= SQ_W'(md4_q) * SQ_W'(md4_q);
      sx5_q   <= sx4_q;
      sy5_q   <= sy4_q;
      t5_q    <= t4_q;
      ut5_q   <= ut4_q;
      sb5_q   <= sb4_q;
    end
  end

  assign valid_o = v_q[4];
  assign rad_o   = e_u[E_W-1] ? '0 : (spcf_pkg::RAD_W'(e_u[E_W-2:0]) << FB);
  assign side_o  = '{ut: ut5_q, sb: sb5_q, t: t5_q};

endmodule

@@ design/spcf_sqrt.sv @@
module spcf_sqrt #(
  parameter int RAD_W  = 64,
  parameter int SIDE_W = 8
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  en_i,
  input  logic                  valid_i,
  input  logic [RAD_W-1:0]      rad_i,
  input  logic [SIDE_W-1:0]     side_i,
  output logic                  valid_o,
  output logic [RAD_W/2-1:0]    root_o,
  output logic [SIDE_W-1:0]     side_o
);

  localparam int ROOT_W = RAD_W / 2;
  localparam int STEP_N = 2;
  localparam int STG_N  = ROOT_W / STEP_N;
  localparam int REM_W  = ROOT_W + 3;

  logic [STG_N:0]      v_q;
  logic [RAD_W-1:0]    rad_q  [STG_N+1];
  logic [REM_W-1:0]    rem_q  [STG_N+1];
  logic [ROOT_W-1:0]   root_q [STG_N+1];
  logic [SIDE_W-1:0]   side_q [STG_N+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[STG_N-1:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rad_q[0]  <= rad_i;
      rem_q[0]  <= '0;
      root_q[0] <= '0;
      side_q[0] <= side_i;
    end
  end

  for (genvar g = 0; g < STG_N; g++) begin : g_stg
    logic [REM_W-1:0]  rem_n, rem_s, trial;
    logic [ROOT_W-1:0] root_n;
    logic [RAD_W-1:0]  rad_n;

    always_comb begin
      rem_n  = rem_q[g];
      root_n = root_q[g];
      rad_n  = rad_q[g];
      rem_s  = '0;
      trial  = '0;
      for (int k = 0; k < STEP_N; k++) begin
        rem_s = {rem_n[REM_W-3:0], rad_n[RAD_W-1 -: 2]};
        trial = {1'b0, root_n, 2'b01};
        if (rem_s >= trial) begin
          rem_n  = rem_s - trial;
          root_n = {root_n[ROOT_W-2:0], 1'b1};
        end else begin
          rem_n  = rem_s;
          root_n = {root_n[ROOT_W-2:0], 1'b0};
        end
        rad_n = {rad_n[RAD_W-3:0], 2'b00};
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rad_q[g+1]  <= rad_n;
        rem_q[g+1]  <= rem_n;
        root_q[g+1] <= root_n;
        side_q[g+1] <= side_q[g];
      end
    end
  end

  assign valid_o = v_q[STG_N];
  assign root_o  = root_q[STG_N];
  assign side_o  = side_q[STG_N];

endmodule

@@ design/spcf_checker.sv @@
`include "sphere_point_to_cube_face_defines.svh"

module spcf_checker (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              in_stall_o,
  input logic                              out_valid_o,
  input logic                              out_stall_i,
  input logic [2:0]                        face_o,
  input logic signed [spcf_pkg::IO_W-1:0]  face_u_o,
  input logic signed [spcf_pkg::IO_W-1:0]  face_v_o
);

  localparam logic signed [spcf_pkg::IO_W-1:0] ONE_O =
    spcf_pkg::IO_W'(1) <<< spcf_pkg::FRAC_BITS;

  `SPCF_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i,
    out_valid_o && $stable(face_o) && $stable(face_u_o) && $stable(face_v_o),
    "stalled result changed")
  `SPCF_ASSERT_NOW(a_stall_cause, in_stall_o, out_valid_o && out_stall_i,
    "input stalled without a waiting result")
  `SPCF_ASSERT_NOW(a_face_range, out_valid_o, face_o <= 3'd5, "face out of range")
  `SPCF_ASSERT_NOW(a_coord_range, out_valid_o,
    face_u_o <= ONE_O && face_u_o >= -ONE_O && face_v_o <= ONE_O && face_v_o >= -ONE_O,
    "face coordinate beyond one")

endmodule

bind sphere_point_to_cube_face spcf_checker u_spcf_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .face_o      (face_o),
  .face_u_o    (face_u_o),
  .face_v_o    (face_v_o)
);
